[hdl/multi_key_short_long_press_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the key press classifier
// Shared same-cycle and next-cycle implication checks, gated by reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_SHORT_LONG_PRESS_CLASSIFIER_DEFINES_SVH
`define MULTI_KEY_SHORT_LONG_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define MKSLPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkslpc check failed");

// next-cycle implication
`define MKSLPC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkslpc check failed");

`endif

[hdl/mkslpc_pkg.sv]
// ----------------------------------------------------------------------------
// Key press classifier package
// Key indexes, register indexes, widths and the lane status type.
// ----------------------------------------------------------------------------
package mkslpc_pkg;

   localparam int NUM_KEYS         = 6;
   localparam int KEY_FUNCTION     = 0;
   localparam int KEY_POWER        = 1;
   localparam int FIRST_ADJUST_KEY = 2;

   localparam int TIME_WIDTH_DEF = 16;
   localparam int NOW_W          = 16;
   localparam int THRESH_W       = 16;
   localparam int EVENT_W        = 4;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_TICKS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUNC_LONG_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWR_LONG_TICKS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADJ_LONG_TICKS  = 2'd3;

   localparam logic [THRESH_W-1:0] SHORT_TICKS_RST     = 16'd10;
   localparam logic [THRESH_W-1:0] FUNC_LONG_TICKS_RST = 16'd600;
   localparam logic [THRESH_W-1:0] PWR_LONG_TICKS_RST  = 16'd400;
   localparam logic [THRESH_W-1:0] ADJ_LONG_TICKS_RST  = 16'd80;

   localparam logic [EVENT_W-1:0] EVENT_NONE = 4'd0;

   // what one lane reports for the item on its inputs
   typedef struct packed {
      logic release_hit;  // power key let go after short, never long
      logic press_hit;    // threshold crossed on this sample, not for power's short
      logic press_long;   // the crossing was the long one
      logic long_held;    // key currently held past long
   } lane_status_type;

endpackage

[hdl/mkslpc_lane.sv]
// ----------------------------------------------------------------------------
// Key press classifier lane
// Press tracking for one key: start time, held, short and long flags.
// ----------------------------------------------------------------------------
`include "multi_key_short_long_press_classifier_defines.svh"

module mkslpc_lane #(
   parameter int TIME_WIDTH = mkslpc_pkg::TIME_WIDTH_DEF,
   parameter int KEY_INDEX  = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            scan_en,
   input  logic                            pin_level,
   input  logic [TIME_WIDTH-1:0]           now,
   input  logic [mkslpc_pkg::THRESH_W-1:0] short_ticks,
   input  logic [mkslpc_pkg::THRESH_W-1:0] long_ticks,
   output mkslpc_pkg::lane_status_type     status
);

   localparam int CMP_W = (TIME_WIDTH > mkslpc_pkg::THRESH_W) ?
                          TIME_WIDTH : mkslpc_pkg::THRESH_W;
   localparam bit IS_POWER = (KEY_INDEX == mkslpc_pkg::KEY_POWER);

   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic                  held_ff, held_in;
   logic                  short_ff, short_in;
   logic                  long_ff, long_in;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  over_short, over_long;

   assign elapsed    = now - start_ff;
   assign over_short = CMP_W'(elapsed) > CMP_W'(short_ticks);
   assign over_long  = CMP_W'(elapsed) > CMP_W'(long_ticks);

   always_comb begin
      start_in = start_ff;
      held_in  = held_ff;
      short_in = short_ff;
      long_in  = long_ff;
      status   = '0;
      status.long_held = long_ff;
      if (pin_level) begin
         if (held_ff) begin
            status.release_hit = IS_POWER && short_ff && !long_ff;
            held_in  = 1'b0;
            short_in = 1'b0;
            long_in  = 1'b0;
         end
      end else if (!held_ff) begin
         start_in = now;
         held_in  = 1'b1;
         short_in = 1'b0;
         long_in  = 1'b0;
      end else if (!short_ff) begin
         if (over_short) begin
            short_in = 1'b1;
            // power reports its short press on release instead
            status.press_hit = !IS_POWER;
         end
      end else if (!long_ff) begin
         if (over_long) begin
            long_in = 1'b1;
            status.press_hit  = 1'b1;
            status.press_long = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_en) begin
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         short_ff <= 1'b0;
         long_ff  <= 1'b0;
      end else if (scan_en) begin
         held_ff  <= held_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   `MKSLPC_ASSERT_IMP(a_short_needs_held, clock, reset, short_ff, held_ff)
   `MKSLPC_ASSERT_IMP(a_long_needs_short, clock, reset, long_ff, short_ff)
   `MKSLPC_ASSERT_NXT(a_start_captured, clock, reset,
      scan_en && !pin_level && !held_ff, held_ff && start_ff == $past(now))

endmodule

[hdl/mkslpc_merge.sv]
// ----------------------------------------------------------------------------
// Key press classifier merge
// Combines lane reports into one event code and holds it for the output.
// ----------------------------------------------------------------------------
`include "multi_key_short_long_press_classifier_defines.svh"

module mkslpc_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  mkslpc_pkg::lane_status_type       lane_status [mkslpc_pkg::NUM_KEYS],
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mkslpc_pkg::EVENT_W-1:0]    rsp_key_event
);

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mkslpc_pkg::EVENT_W-1:0]   event_ff, event_in;
   logic                             accept;
   logic                             any_long;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = event_ff;

   always_comb begin
      event_in = mkslpc_pkg::EVENT_NONE;
      any_long = 1'b0;
      if (req_func) begin
         // repeat tick: highest adjust key held long wins
         for (int k = mkslpc_pkg::FIRST_ADJUST_KEY; k < mkslpc_pkg::NUM_KEYS; k++) begin
            if (lane_status[k].long_held) begin
               event_in = mkslpc_pkg::EVENT_W'(2 * k + 1);
               any_long = 1'b1;
            end
         end
      end else begin
         // releases come first, presses after, later write wins
         for (int k = 0; k < mkslpc_pkg::NUM_KEYS; k++) begin
            if (lane_status[k].release_hit) begin
               event_in = mkslpc_pkg::EVENT_W'(2 * k + 1);
            end
         end
         for (int k = 0; k < mkslpc_pkg::NUM_KEYS; k++) begin
            if (lane_status[k].press_hit) begin
               event_in = mkslpc_pkg::EVENT_W'(2 * k + 1 + int'(lane_status[k].press_long));
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_in;
      end
   end

   `MKSLPC_ASSERT_NXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff)
   `MKSLPC_ASSERT_IMP(a_event_range, clock, reset, rsp_valid_ff, event_ff <= 4'd12)
   `MKSLPC_ASSERT_NXT(a_idle_repeat_quiet, clock, reset,
      accept && req_func && !any_long, event_ff == mkslpc_pkg::EVENT_NONE)

endmodule

[hdl/multi_key_short_long_press_classifier.sv]
// A result is registered and valid in the cycle after its item is accepted.
// One item per cycle is taken while the output register is free or its result is taken.
// The output register frees itself in the cycle its result is taken.
// Reset clears key flags and output valid, and loads the default thresholds.
// ----------------------------------------------------------------------------
// Multi-key short/long press classifier
// Six key lanes track presses in parallel; a merge stage picks the event.
// ----------------------------------------------------------------------------
module multi_key_short_long_press_classifier #(
   parameter int TIME_WIDTH = mkslpc_pkg::TIME_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [mkslpc_pkg::NUM_KEYS-1:0]    req_pin_levels,
   input  logic [mkslpc_pkg::NOW_W-1:0]       req_now_ticks,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mkslpc_pkg::EVENT_W-1:0]     rsp_key_event,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mkslpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkslpc_pkg::THRESH_W-1:0]    csr_wdata
);

   logic [mkslpc_pkg::THRESH_W-1:0] short_ticks_ff;
   logic [mkslpc_pkg::THRESH_W-1:0] func_long_ff;
   logic [mkslpc_pkg::THRESH_W-1:0] pwr_long_ff;
   logic [mkslpc_pkg::THRESH_W-1:0] adj_long_ff;
   logic                            scan_en;
   logic [TIME_WIDTH-1:0]           now;
   mkslpc_pkg::lane_status_type     lane_status [mkslpc_pkg::NUM_KEYS];

   assign csr_ready = 1'b1;
   assign scan_en   = req_valid && req_ready && !req_func;
   assign now       = TIME_WIDTH'(req_now_ticks);

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ticks_ff <= mkslpc_pkg::SHORT_TICKS_RST;
         func_long_ff   <= mkslpc_pkg::FUNC_LONG_TICKS_RST;
         pwr_long_ff    <= mkslpc_pkg::PWR_LONG_TICKS_RST;
         adj_long_ff    <= mkslpc_pkg::ADJ_LONG_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            mkslpc_pkg::CSR_SHORT_TICKS:     short_ticks_ff <= csr_wdata;
            mkslpc_pkg::CSR_FUNC_LONG_TICKS: func_long_ff   <= csr_wdata;
            mkslpc_pkg::CSR_PWR_LONG_TICKS:  pwr_long_ff    <= csr_wdata;
            mkslpc_pkg::CSR_ADJ_LONG_TICKS:  adj_long_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < mkslpc_pkg::NUM_KEYS; k++) begin : g_lane
      logic [mkslpc_pkg::THRESH_W-1:0] long_ticks;

      if (k == mkslpc_pkg::KEY_FUNCTION) begin : g_func
         assign long_ticks = func_long_ff;
      end else if (k == mkslpc_pkg::KEY_POWER) begin : g_pwr
         assign long_ticks = pwr_long_ff;
      end else begin : g_adj
         assign long_ticks = adj_long_ff;
      end

      mkslpc_lane #(
         .TIME_WIDTH (TIME_WIDTH),
         .KEY_INDEX  (k)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .scan_en     (scan_en),
         .pin_level   (req_pin_levels[k]),
         .now         (now),
         .short_ticks (short_ticks_ff),
         .long_ticks  (long_ticks),
         .status      (lane_status[k])
      );
   end

   mkslpc_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .lane_status   (lane_status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_event (rsp_key_event)
   );

endmodule

[sim/tb_multi_key_short_long_press_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-key short/long press classifier
// Drives directed and random key scan and repeat items through the block.
// Several threshold settings are used, with random idle and stall cycles on
// both channels. Every result is checked against an in-bench predictor of the
// six key lanes.
// ----------------------------------------------------------------------------
module tb_multi_key_short_long_press_classifier;
   import mkslpc_pkg::*;

   localparam logic FUNC_SCAN   = 1'b0;
   localparam logic FUNC_REPEAT = 1'b1;

   typedef struct packed {
      logic                func;
      logic [NUM_KEYS-1:0] pins;
      logic [NOW_W-1:0]    now;
   } key_scan_t;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic                   req_func       = FUNC_SCAN;
   logic [NUM_KEYS-1:0]    req_pin_levels = '1;
   logic [NOW_W-1:0]       req_now_ticks  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [EVENT_W-1:0]     rsp_key_event;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [THRESH_W-1:0]    csr_wdata      = '0;

   // predictor state and thresholds
   logic [NOW_W-1:0]    press_start [NUM_KEYS] = '{default: '0};
   logic [NUM_KEYS-1:0] held_keys   = '0;
   logic [NUM_KEYS-1:0] short_keys  = '0;
   logic [NUM_KEYS-1:0] long_keys   = '0;
   logic [THRESH_W-1:0] short_ticks     = SHORT_TICKS_RST;
   logic [THRESH_W-1:0] func_long_ticks = FUNC_LONG_TICKS_RST;
   logic [THRESH_W-1:0] pwr_long_ticks  = PWR_LONG_TICKS_RST;
   logic [THRESH_W-1:0] adj_long_ticks  = ADJ_LONG_TICKS_RST;

   key_scan_t          pending_scans [$];
   logic [EVENT_W-1:0] expected_events [$];
   key_scan_t          next_scan;
   logic [EVENT_W-1:0] want_event;

   int error_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int hold_len      = 0;
   int hold_tag      = 0;
   int hold_tag_seen = 0;

   logic [NUM_KEYS-1:0] gen_pins = '1;
   logic [NOW_W-1:0]    gen_now  = '0;

   multi_key_short_long_press_classifier u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_pin_levels (req_pin_levels),
      .req_now_ticks  (req_now_ticks),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_event  (rsp_key_event),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   // advances the key state for one item and returns its event
   function automatic logic [EVENT_W-1:0] classify_scan(key_scan_t it);
      logic [EVENT_W-1:0] ev;
      logic [NOW_W-1:0]   elapsed;
      logic [THRESH_W-1:0] long_ticks;
      ev = EVENT_NONE;
      if (it.func == FUNC_REPEAT) begin
         for (int k = FIRST_ADJUST_KEY; k < NUM_KEYS; k++) begin
            if (long_keys[k]) ev = EVENT_W'(2 * k + 1);
         end
         return ev;
      end
      // releases first
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (held_keys[k] && it.pins[k]) begin
            if (k == KEY_POWER && short_keys[k] && !long_keys[k]) ev = EVENT_W'(2 * k + 1);
            held_keys[k]  = 1'b0;
            short_keys[k] = 1'b0;
            long_keys[k]  = 1'b0;
         end
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (!it.pins[k]) begin
            if (!held_keys[k]) begin
               press_start[k] = it.now;
               held_keys[k]   = 1'b1;
               short_keys[k]  = 1'b0;
               long_keys[k]   = 1'b0;
            end else begin
               elapsed = it.now - press_start[k];
               if (k == KEY_FUNCTION) long_ticks = func_long_ticks;
               else if (k == KEY_POWER) long_ticks = pwr_long_ticks;
               else long_ticks = adj_long_ticks;
               if (!short_keys[k]) begin
                  if (elapsed > short_ticks) begin
                     short_keys[k] = 1'b1;
                     // power short only shows on release
                     if (k != KEY_POWER) ev = EVENT_W'(2 * k + 1);
                  end
               end else if (!long_keys[k]) begin
                  if (elapsed > long_ticks) begin
                     long_keys[k] = 1'b1;
                     ev = EVENT_W'(2 * k + 2);
                  end
               end
            end
         end
      end
      return ev;
   endfunction

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_events.push_back(
               classify_scan(key_scan_t'({req_func, req_pin_levels, req_now_ticks})));
         end
         if (!req_valid || req_ready) begin
            if (pending_scans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_scan = pending_scans.pop_front();
               req_func       <= next_scan.func;
               req_pin_levels <= next_scan.pins;
               req_now_ticks  <= next_scan.now;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver hold-off counter
   always @(posedge clock) begin
      if (hold_tag != hold_tag_seen) begin
         hold_tag_seen <= hold_tag;
         hold_left     <= hold_len;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected result, expected none, got key_event %0d",
                        $time, rsp_key_event);
               error_count++;
            end else begin
               want_event = expected_events.pop_front();
               if (rsp_key_event !== want_event) begin
                  $display("%0t: key_event mismatch, expected %0d, got %0d",
                           $time, want_event, rsp_key_event);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic push_scan(input logic func, input logic [NUM_KEYS-1:0] pins,
                            input logic [NOW_W-1:0] now);
      key_scan_t it;
      it.func = func;
      it.pins = pins;
      it.now  = now;
      pending_scans.push_back(it);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_scans.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // called right after a rising edge; csr_valid stays high between writes
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [THRESH_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_SHORT_TICKS:     short_ticks     = val;
         CSR_FUNC_LONG_TICKS: func_long_ticks = val;
         CSR_PWR_LONG_TICKS:  pwr_long_ticks  = val;
         default:             adj_long_ticks  = val;
      endcase
   endtask

   task automatic run_phase(input logic [THRESH_W-1:0] s_ticks, f_ticks, p_ticks, a_ticks,
                            input int send_pct, input int stall_pct, input int step_max,
                            input int num_items, input int hold_cycles);
      int r;
      logic [NOW_W-1:0] rnd_now;
      logic [NUM_KEYS-1:0] rnd_pins;
      wait_drained();
      write_csr(CSR_SHORT_TICKS, s_ticks);
      write_csr(CSR_FUNC_LONG_TICKS, f_ticks);
      write_csr(CSR_PWR_LONG_TICKS, p_ticks);
      write_csr(CSR_ADJ_LONG_TICKS, a_ticks);
      csr_valid <= 1'b0;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < num_items; i++) begin
         r        = $urandom_range(99);
         rnd_pins = NUM_KEYS'($urandom);
         rnd_now  = NOW_W'($urandom);
         if (r < 12) begin
            push_scan(FUNC_REPEAT, rnd_pins, rnd_now);
         end else if (r < 20) begin
            // noise: random pins and a time jump, breaks running presses
            push_scan(FUNC_SCAN, rnd_pins, rnd_now);
         end else begin
            gen_now = gen_now + NOW_W'($urandom_range(0, step_max));
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (gen_pins[k]) begin
                  if ($urandom_range(7) == 0) gen_pins[k] = 1'b0;
               end else if ($urandom_range(19) == 0) begin
                  gen_pins[k] = 1'b1;
               end
            end
            push_scan(FUNC_SCAN, gen_pins, gen_now);
         end
      end
      // long receiver hold-off while items keep coming
      if (hold_cycles > 0) begin
         hold_len = hold_cycles;
         hold_tag++;
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset thresholds
      push_scan(FUNC_SCAN,   6'b111111, 16'h0000);
      push_scan(FUNC_REPEAT, 6'b000000, 16'hffff);
      push_scan(FUNC_SCAN,   6'b000000, 16'hfff8);
      push_scan(FUNC_SCAN,   6'b000000, 16'h0004); // elapsed wraps past zero
      push_scan(FUNC_SCAN,   6'b000000, 16'h0050);
      push_scan(FUNC_REPEAT, 6'b101010, 16'h1234);
      push_scan(FUNC_SCAN,   6'b000010, 16'h0060); // power let go after short
      push_scan(FUNC_SCAN,   6'b111100, 16'h0070);
      push_scan(FUNC_REPEAT, 6'b111111, 16'h0000);
      push_scan(FUNC_SCAN,   6'b111110, 16'h0260);
      push_scan(FUNC_SCAN,   6'b111111, 16'h0300);
      push_scan(FUNC_SCAN,   6'b111101, 16'h1000);
      push_scan(FUNC_SCAN,   6'b111101, 16'h1010); // power short stays silent
      push_scan(FUNC_SCAN,   6'b111101, 16'h1200);
      push_scan(FUNC_SCAN,   6'b111111, 16'h1201); // power let go after long
      push_scan(FUNC_SCAN,   6'b111011, 16'h2000);
      push_scan(FUNC_SCAN,   6'b111011, 16'h2100); // short only, long waits a sample
      push_scan(FUNC_SCAN,   6'b111011, 16'h2101);
      push_scan(FUNC_SCAN,   6'b110111, 16'h3000);
      push_scan(FUNC_SCAN,   6'b110111, 16'h300a); // equal to threshold is not enough
      push_scan(FUNC_SCAN,   6'b110111, 16'h300b);
      push_scan(FUNC_SCAN,   6'b111111, 16'hffff);

      run_phase(16'd10, 16'd600, 16'd400, 16'd80, 0, 0, 40, 350, 0);
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 73, 0, 3, 300, 0);
      run_phase(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 73, 8000, 250, 0);
      run_phase(16'd3, 16'd40, 16'd25, 16'd12, 6, 6, 6, 350, 400);
      run_phase(16'd1, 16'hffff, 16'd2, 16'hfffe, 0, 0, 5, 350, 0);
      run_phase(16'd12, 16'd200, 16'd120, 16'd50, 0, 73, 20, 350, 0);

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS multi_key_short_long_press_classifier");
      end else begin
         $display("FAIL multi_key_short_long_press_classifier");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL multi_key_short_long_press_classifier");
      $finish;
   end

endmodule
